[rtl/lcd_command_to_serial_bridge_defines.svh]
// assertion macros used by the checker file of the lcd command to serial bridge
`ifndef LCD_COMMAND_TO_SERIAL_BRIDGE_DEFINES_SVH
`define LCD_COMMAND_TO_SERIAL_BRIDGE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LCDSB_ASSERT_NOW(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("lcdsb check failed");

// next-cycle implication, disabled while reset is asserted
`define LCDSB_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("lcdsb check failed");

`endif

[rtl/lcdsb_pkg.sv]
// types and constants shared by the lcd command to serial bridge modules
`default_nettype none

package lcdsb_pkg;

	// input request: one controller instruction or data byte
	typedef struct packed {
		logic       command;
		logic [7:0] value;
	} cmd_req_t;

	// output request: one byte for the serial link
	typedef struct packed {
		logic [7:0] serial_byte;
		logic       last;
	} ser_req_t;

	typedef struct packed {
		logic       device_type;
		logic [3:0] cell_height;
		logic       extended_mode;
	} cfg_t;

	// configuration port
	localparam int unsigned CFG_DATA_W = 4;
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_DEVICE_TYPE   = 2'd0;
	localparam cfg_idx_t CFG_CELL_HEIGHT   = 2'd1;
	localparam cfg_idx_t CFG_EXTENDED_MODE = 2'd2;
	localparam logic [3:0] CELL_HEIGHT_RST = 4'd8;

	// one burst of up to five serial bytes, first byte in slot 0
	localparam int unsigned BURST_MAX = 5;
	localparam int unsigned LEN_W     = 3;
	typedef struct packed {
		logic [LEN_W-1:0]          len;
		logic [BURST_MAX-1:0][7:0] bytes;
	} burst_t;

	localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
	localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
	localparam logic [LEN_W-1:0] LEN_POS   = 3'd4;
	localparam logic [LEN_W-1:0] LEN_GLYPH = 3'd5;

	// decoupling queue, depth must be a power of two
	localparam int unsigned QUEUE_DEPTH = 2;

	// serial protocol bytes
	localparam logic [7:0] PREFIX       = 8'h00;
	localparam logic [7:0] POS_ROW_BASE = 8'hA1;
	localparam logic [7:0] POS_END      = 8'hA7;
	localparam logic [7:0] GLYPH_ROW    = 8'hAB;

	// plain data offsets away from the prefix
	localparam logic [7:0] PLAIN_LIMIT_T0 = 8'd7;
	localparam logic [7:0] PLAIN_OFS_T0   = 8'd1;
	localparam logic [7:0] PLAIN_LIMIT_T1 = 8'd8;
	localparam logic [7:0] PLAIN_OFS_T1   = 8'd8;

	localparam logic [2:0] SLOT_MAX = 3'd7;

endpackage

`default_nettype wire

[rtl/lcdsb_front.sv]
// front part: accepts controller bytes, tracks glyph define state, builds bursts
`default_nettype none

module lcdsb_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lcdsb_pkg::cfg_t     cfg,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire lcdsb_pkg::cmd_req_t cmd,
	input  wire logic                q_full,
	output logic                     q_push,
	output lcdsb_pkg::burst_t        q_data
);

	logic       define_mode_q;
	logic [2:0] glyph_slot_q;
	logic [7:0] row_count_q;

	logic       define_mode_d;
	logic [2:0] glyph_slot_d;
	logic [7:0] row_count_d;
	logic [7:0] row_inc;
	logic [7:0] cell_height_ext;
	logic [3:0] slot_sum;
	logic [7:0] pos_row;
	logic [7:0] pos_col;
	logic       accept;
	lcdsb_pkg::burst_t burst;

	assign cmd_stall = q_full;
	assign accept    = cmd_valid && !q_full;

	assign row_inc         = row_count_q + 8'd1;
	assign cell_height_ext = {4'd0, cfg.cell_height};
	assign slot_sum        = {1'b0, cmd.value[5:3]} + 4'd1;

	// address split by 32 per row in extended mode, else by 64
	assign pos_row = cfg.extended_mode ? {6'd0, cmd.value[6:5]} : {7'd0, cmd.value[6]};
	assign pos_col = cfg.extended_mode ? {3'd0, cmd.value[4:0]} : {2'd0, cmd.value[5:0]};

	always_comb begin
		burst         = '0;
		burst.len     = lcdsb_pkg::LEN_NONE;
		define_mode_d = define_mode_q;
		glyph_slot_d  = glyph_slot_q;
		row_count_d   = row_count_q;
		if (cmd.command) begin
			if (define_mode_q) begin
				row_count_d = row_inc;
				if (!cfg.device_type) begin
					if (row_count_q < cell_height_ext) begin
						burst.len      = lcdsb_pkg::LEN_GLYPH;
						burst.bytes[0] = lcdsb_pkg::PREFIX;
						burst.bytes[1] = lcdsb_pkg::GLYPH_ROW;
						burst.bytes[2] = {5'd0, glyph_slot_q};
						burst.bytes[3] = row_count_q;
						burst.bytes[4] = cmd.value;
					end else begin
						define_mode_d = 1'b0;
					end
				end else if (row_inc == cell_height_ext) begin
					define_mode_d = 1'b0;
				end
			end else begin
				burst.len      = lcdsb_pkg::LEN_ONE;
				burst.bytes[0] = cmd.value;
				if (!cfg.device_type) begin
					if (cmd.value < lcdsb_pkg::PLAIN_LIMIT_T0) begin
						burst.bytes[0] = cmd.value + lcdsb_pkg::PLAIN_OFS_T0;
					end
				end else if (cmd.value < lcdsb_pkg::PLAIN_LIMIT_T1) begin
					burst.bytes[0] = cmd.value + lcdsb_pkg::PLAIN_OFS_T1;
				end
			end
		end else if (cmd.value[7]) begin
			burst.len      = lcdsb_pkg::LEN_POS;
			burst.bytes[0] = lcdsb_pkg::PREFIX;
			burst.bytes[1] = lcdsb_pkg::POS_ROW_BASE + pos_row;
			burst.bytes[2] = pos_col;
			burst.bytes[3] = lcdsb_pkg::POS_END;
		end else if (cmd.value[6]) begin
			// slot index plus one, clamped to the top slot
			glyph_slot_d  = slot_sum[3] ? lcdsb_pkg::SLOT_MAX : slot_sum[2:0];
			define_mode_d = 1'b1;
			row_count_d   = 8'd0;
		end else begin
			burst.len      = lcdsb_pkg::LEN_ONE;
			burst.bytes[0] = cmd.value;
		end
	end

	assign q_push = accept && (burst.len != lcdsb_pkg::LEN_NONE);
	assign q_data = burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			define_mode_q <= 1'b0;
			glyph_slot_q  <= 3'd0;
			row_count_q   <= 8'd0;
		end else if (accept) begin
			define_mode_q <= define_mode_d;
			glyph_slot_q  <= glyph_slot_d;
			row_count_q   <= row_count_d;
		end
	end

endmodule

`default_nettype wire

[rtl/lcdsb_queue.sv]
// short burst queue between the front and back parts
`default_nettype none

module lcdsb_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lcdsb_pkg::burst_t push_data,
	input  wire logic              pop,
	output lcdsb_pkg::burst_t      pop_data,
	output logic                   full,
	output logic                   empty
);

	localparam int unsigned PTR_W = $clog2(lcdsb_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(lcdsb_pkg::QUEUE_DEPTH + 1);

	lcdsb_pkg::burst_t mem_q [lcdsb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(lcdsb_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/lcdsb_back.sv]
// back part: drains bursts onto the serial channel one byte per cycle while the receiver does not stall
`default_nettype none

module lcdsb_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire lcdsb_pkg::burst_t q_data,
	output logic                   q_pop,
	output logic                   ser_valid,
	input  wire logic              ser_stall,
	output lcdsb_pkg::ser_req_t    ser
);

	localparam int unsigned REST_N = lcdsb_pkg::BURST_MAX - 1;

	logic                              ser_valid_q;
	lcdsb_pkg::ser_req_t               ser_q;
	logic [lcdsb_pkg::LEN_W-1:0]       rem_q;
	logic [REST_N-1:0][7:0]            rest_q;
	logic                              out_free;
	logic                              busy;

	assign out_free = !ser_valid_q || !ser_stall;
	assign busy     = (rem_q != lcdsb_pkg::LEN_NONE);
	assign q_pop    = out_free && !busy && !q_empty;

	assign ser_valid = ser_valid_q;
	assign ser       = ser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			rem_q       <= lcdsb_pkg::LEN_NONE;
		end else if (out_free) begin
			if (busy) begin
				ser_valid_q <= 1'b1;
				rem_q       <= rem_q - lcdsb_pkg::LEN_ONE;
			end else if (!q_empty) begin
				ser_valid_q <= 1'b1;
				rem_q       <= q_data.len - lcdsb_pkg::LEN_ONE;
			end else begin
				ser_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (busy) begin
				ser_q.serial_byte <= rest_q[0];
				ser_q.last        <= (rem_q == lcdsb_pkg::LEN_ONE);
				rest_q            <= {8'd0, rest_q[REST_N-1:1]};
			end else if (!q_empty) begin
				ser_q.serial_byte <= q_data.bytes[0];
				ser_q.last        <= (q_data.len == lcdsb_pkg::LEN_ONE);
				rest_q            <= q_data.bytes[lcdsb_pkg::BURST_MAX-1:1];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/lcd_command_to_serial_bridge.sv]
// top level of the lcd command to serial bridge
`default_nettype none
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one controller byte per
//   request: cmd.command 0 for an instruction, 1 for a data byte
//   ser channel (ser_valid / ser_stall / ser) gives the serial byte stream,
//   ser.last marks the final byte caused by one cmd request
//   a request can cause zero (glyph define, dropped or absorbed define data),
//   one (plain data or instruction), four (cursor position) or five (glyph row)
//   serial bytes
//   a request taken goes through the burst queue into the output register,
//   where its first serial byte shows; later bytes follow one per cycle
//   while the receiver does not stall; the serial side moves one byte per
//   cycle unless stalled, and the front takes a request every cycle while
//   the two-entry burst queue has room
//   when the receiver stalls, the current byte holds, the queue fills and
//   cmd_stall rises; define-mode state still updates per request taken
//   reset clears define mode, glyph slot, row count and the queue; device
//   type 0, cell height 8, extended mode 0
//   configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   clock edge and must only occur while the block is idle

module lcd_command_to_serial_bridge (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_stall,
	input  wire lcdsb_pkg::cmd_req_t               cmd,
	output logic                                   ser_valid,
	input  wire logic                              ser_stall,
	output lcdsb_pkg::ser_req_t                    ser,
	input  wire logic                              cfg_we,
	input  wire lcdsb_pkg::cfg_idx_t               cfg_index,
	input  wire logic [lcdsb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	lcdsb_pkg::cfg_t   cfg_q;

	// queue signals between front and back
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	lcdsb_pkg::burst_t q_push_data;
	lcdsb_pkg::burst_t q_pop_data;

	// register writes, unused bits of the data word are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_type   <= 1'b0;
			cfg_q.cell_height   <= lcdsb_pkg::CELL_HEIGHT_RST;
			cfg_q.extended_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcdsb_pkg::CFG_DEVICE_TYPE:   cfg_q.device_type   <= cfg_data[0];
				lcdsb_pkg::CFG_CELL_HEIGHT:   cfg_q.cell_height   <= cfg_data[3:0];
				lcdsb_pkg::CFG_EXTENDED_MODE: cfg_q.extended_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: classify the request and build its byte burst
	lcdsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_push_data)
	);

	// bursts wait here so the front and back stall independently
	lcdsb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: serialize bursts into the output register
	lcdsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_pop_data),
		.q_pop     (q_pop),
		.ser_valid (ser_valid),
		.ser_stall (ser_stall),
		.ser       (ser)
	);

endmodule

`default_nettype wire

[rtl/lcdsb_checker.sv]
// port-level checks for the lcd command to serial bridge and their bind
`default_nettype none
`include "lcd_command_to_serial_bridge_defines.svh"

module lcdsb_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_stall,
	input  wire logic                ser_valid,
	input  wire logic                ser_stall,
	input  wire lcdsb_pkg::ser_req_t ser
);

	// a stalled serial byte stays valid
	`LCDSB_ASSERT_NEXT(a_ser_hold, clk, arst_n, ser_valid && ser_stall, ser_valid)

	// a stalled serial byte does not change
	`LCDSB_ASSERT_NEXT(a_ser_stable, clk, arst_n, ser_valid && ser_stall, $stable(ser))

	// a burst leaves without gaps once started
	`LCDSB_ASSERT_NEXT(a_burst_gapless, clk, arst_n,
		ser_valid && !ser_stall && !ser.last, ser_valid)

	// the front only backs up while the serial side has data pending
	`LCDSB_ASSERT_NOW(a_stall_needs_data, clk, arst_n, cmd_stall, ser_valid)

endmodule

bind lcd_command_to_serial_bridge lcdsb_checker u_lcdsb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.ser_valid (ser_valid),
	.ser_stall (ser_stall),
	.ser       (ser)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the lcd command to serial bridge
`timescale 1ns / 1ps

module tb_top;
	import lcdsb_pkg::*;

	// request kind on the cmd channel
	localparam logic CMD_INSTR = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// index past the register list, the block must ignore writes to it
	localparam cfg_idx_t CFG_SPARE = 2'd3;

	localparam int unsigned PHASE_REQUESTS = 33;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned ABSORB_ROWS    = 12;

	typedef enum logic {ROW_SETTINGS, ROW_REQUEST} row_kind_e;

	// one row of the directed table: a settings change or one request,
	// with the serial bytes typed in where they are obvious
	typedef struct {
		row_kind_e         kind;
		cmd_req_t          req;
		bit                typed;
		int                n_typed;
		logic [0:4][7:0]   typed_bytes;
		logic              dev_type;
		logic [3:0]        height;
		logic              split_by_32;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_req_t cmd;
	logic ser_valid;
	logic ser_stall;
	ser_req_t ser;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the configuration
	logic       dev_type;
	logic [3:0] height;
	logic       split_by_32;
	// predictor copy of the glyph define state
	logic       in_define;
	logic [2:0] slot;
	logic [7:0] rows_done;

	ser_req_t   expected_serial[$];
	table_row_t directed_rows[$];
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	// stimulus controls shared with the receiver
	bit steady;
	bit hold_pending;

	always #1 clk = ~clk;

	lcd_command_to_serial_bridge u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.ser_valid (ser_valid),
		.ser_stall (ser_stall),
		.ser       (ser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// serial bytes one request causes, with the define state advanced
	function automatic int predict_serial_bytes(input cmd_req_t r,
		output logic [0:4][7:0] b);
		logic [7:0] v;
		logic [1:0] row;
		logic [5:0] col;
		logic [3:0] s;
		int n;
		n = 0;
		b = '0;
		v = r.value;
		if (r.command == CMD_DATA) begin
			if (in_define) begin
				if (dev_type == 1'b0) begin
					// one glyph row per byte until the cell is full, then drop and leave
					if (rows_done < {4'd0, height}) begin
						b = {PREFIX, GLYPH_ROW, {5'd0, slot}, rows_done, v};
						n = 5;
					end else begin
						in_define = 1'b0;
					end
				end
				rows_done = rows_done + 8'd1;
				// second module type only counts rows, wraps through 255 when height is 0
				if (dev_type == 1'b1 && rows_done == {4'd0, height})
					in_define = 1'b0;
			end else begin
				// plain data moves clear of the prefix byte
				if (dev_type == 1'b0) begin
					if (v < PLAIN_LIMIT_T0)
						v = v + PLAIN_OFS_T0;
				end else if (v < PLAIN_LIMIT_T1) begin
					v = v + PLAIN_OFS_T1;
				end
				b[0] = v;
				n = 1;
			end
		end else if (v[7]) begin
			// cursor position, address split by 32 or 64 per row
			if (split_by_32) begin
				row = v[6:5];
				col = {1'b0, v[4:0]};
			end else begin
				row = {1'b0, v[6]};
				col = v[5:0];
			end
			b = {PREFIX, POS_ROW_BASE + {6'd0, row}, {2'd0, col}, POS_END, 8'h00};
			n = 4;
		end else if (v[6]) begin
			// glyph define: slot one above the cg address, top slot clamped
			s = {1'b0, v[5:3]} + 4'd1;
			if (s > {1'b0, SLOT_MAX})
				s = {1'b0, SLOT_MAX};
			slot = s[2:0];
			in_define = 1'b1;
			rows_done = 8'd0;
		end else begin
			b[0] = v;
			n = 1;
		end
		return n;
	endfunction

	// offer one request, possibly after a gap, and queue what it should cause
	task automatic offer_request(input cmd_req_t r, input bit typed, input int n_typed,
		input logic [0:4][7:0] typed_bytes);
		logic [0:4][7:0] b;
		ser_req_t e;
		int n;
		if (!steady && $urandom_range(99) < 10) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		cmd <= r;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		n = predict_serial_bytes(r, b);
		if (typed) begin
			n = n_typed;
			b = typed_bytes;
		end
		for (int k = 0; k < n; k++) begin
			e.serial_byte = b[k];
			e.last = (k == n - 1);
			expected_serial.push_back(e);
		end
	endtask

	// stop offering, wait for every serial byte, then let the pipe run dry
	task automatic settle();
		cmd_valid <= 1'b0;
		while (expected_serial.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all registers, junk in the unused bits and the spare index
	task automatic apply_settings(input logic t, input logic [3:0] h, input logic e);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEVICE_TYPE;
		cfg_data <= {3'($urandom), t};
		@(posedge clk);
		dev_type = t;
		cfg_index <= CFG_CELL_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		height = h;
		cfg_index <= CFG_EXTENDED_MODE;
		cfg_data <= {3'($urandom), e};
		@(posedge clk);
		split_by_32 = e;
		cfg_index <= CFG_SPARE;
		cfg_data <= 4'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_request(input logic command, input logic [7:0] value, input bit typed,
		input int n_typed, input logic [0:4][7:0] typed_bytes);
		table_row_t row;
		row.kind = ROW_REQUEST;
		row.req.command = command;
		row.req.value = value;
		row.typed = typed;
		row.n_typed = n_typed;
		row.typed_bytes = typed_bytes;
		row.dev_type = 1'b0;
		row.height = 4'd0;
		row.split_by_32 = 1'b0;
		directed_rows.push_back(row);
	endtask

	task automatic add_settings(input logic t, input logic [3:0] h, input logic e);
		table_row_t row;
		row.kind = ROW_SETTINGS;
		row.req = '0;
		row.typed = 1'b0;
		row.n_typed = 0;
		row.typed_bytes = '0;
		row.dev_type = t;
		row.height = h;
		row.split_by_32 = e;
		directed_rows.push_back(row);
	endtask

	// mostly well formed glyph sequences and position / data requests, some noise
	task automatic random_phase(input int unsigned count);
		cmd_req_t r;
		int unsigned sent;
		int unsigned pick;
		int unsigned rows;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				// glyph define then rows, running a little past the cell height
				r.command = CMD_INSTR;
				r.value = {2'b01, 6'($urandom)};
				offer_request(r, 1'b0, 0, '0);
				sent++;
				rows = $urandom_range(height + 2);
				repeat (rows) begin
					r.command = CMD_DATA;
					r.value = 8'($urandom);
					offer_request(r, 1'b0, 0, '0);
					sent++;
				end
			end else begin
				if (pick < 50) begin
					r.command = CMD_INSTR;
					r.value = {1'b1, 7'($urandom)};
				end else if (pick < 72) begin
					// lean on the small values that get moved off the prefix
					r.command = CMD_DATA;
					r.value = $urandom_range(1) ? 8'($urandom_range(9)) : 8'($urandom);
				end else if (pick < 88) begin
					r.command = CMD_INSTR;
					r.value = {2'b00, 6'($urandom)};
				end else begin
					r.command = 1'($urandom);
					r.value = 8'($urandom);
				end
				offer_request(r, 1'b0, 0, '0);
				sent++;
			end
		end
	endtask

	// receiver: random stalls, a quiet stretch, and one long hold-off
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		ser_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ser_stall <= 1'b1;
			end else begin
				ser_stall <= steady ? 1'b0 : ($urandom_range(99) < 10);
			end
		end
	end

	// compare every serial byte taken with the oldest expectation
	always @(posedge clk) begin
		ser_req_t e;
		if (arst_n && ser_valid && !ser_stall) begin
			if (expected_serial.size() == 0) begin
				$error("serial_byte: nothing expected, actual 0x%02h last %0d",
					ser.serial_byte, ser.last);
				mismatch_count++;
			end else begin
				e = expected_serial.pop_front();
				if (ser.serial_byte !== e.serial_byte) begin
					$error("serial_byte: expected 0x%02h, actual 0x%02h",
						e.serial_byte, ser.serial_byte);
					mismatch_count++;
				end
				if (ser.last !== e.last) begin
					$error("last: expected %0d, actual %0d", e.last, ser.last);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: too long with no request moving on any port
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (ser_valid && !ser_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		cmd_req_t r;
		mismatch_count = 0;
		steady = 1'b0;
		hold_pending = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEVICE_TYPE;
		cfg_data = '0;
		// register and state values after reset
		dev_type = 1'b0;
		height = CELL_HEIGHT_RST;
		split_by_32 = 1'b0;
		in_define = 1'b0;
		slot = 3'd0;
		rows_done = 8'd0;

		// directed table, reset settings first
		add_request(CMD_INSTR, 8'h00, 1, 1, {8'h00, 32'h0});
		add_request(CMD_INSTR, 8'h80, 1, 4, {8'h00, 8'hA1, 8'h00, 8'hA7, 8'h00});
		add_request(CMD_INSTR, 8'hFF, 1, 4, {8'h00, 8'hA2, 8'h3F, 8'hA7, 8'h00});
		add_request(CMD_DATA, 8'h00, 1, 1, {8'h01, 32'h0});
		add_request(CMD_DATA, 8'h06, 1, 1, {8'h07, 32'h0});
		add_request(CMD_DATA, 8'h07, 1, 1, {8'h07, 32'h0});
		add_request(CMD_DATA, 8'hFF, 1, 1, {8'hFF, 32'h0});
		// glyph define into slot 1, first row typed, rest of the cell predicted
		add_request(CMD_INSTR, 8'h40, 1, 0, '0);
		add_request(CMD_DATA, 8'hAA, 1, 5, {8'h00, 8'hAB, 8'h01, 8'h00, 8'hAA});
		for (int k = 1; k < 8; k++)
			add_request(CMD_DATA, 8'(k * 17), 0, 0, '0);
		// one past the cell height: dropped, define mode ends
		add_request(CMD_DATA, 8'h5A, 0, 0, '0);
		// top cg address clamps to slot 7
		add_request(CMD_INSTR, 8'h7F, 1, 0, '0);
		add_request(CMD_DATA, 8'h55, 1, 5, {8'h00, 8'hAB, 8'h07, 8'h00, 8'h55});
		add_request(CMD_INSTR, 8'h38, 1, 1, {8'h38, 32'h0});
		// extended mode splits the address by 32; a one-row cell drops the next
		// data byte and ends define mode
		add_settings(1'b0, 4'd1, 1'b1);
		add_request(CMD_DATA, 8'h33, 1, 0, '0);
		add_request(CMD_INSTR, 8'hFF, 1, 4, {8'h00, 8'hA4, 8'h1F, 8'hA7, 8'h00});
		add_request(CMD_INSTR, 8'hA0, 0, 0, '0);
		// second module type offsets small data by 8
		add_settings(1'b1, 4'd8, 1'b1);
		add_request(CMD_DATA, 8'h00, 1, 1, {8'h08, 32'h0});
		add_request(CMD_DATA, 8'h07, 1, 1, {8'h0F, 32'h0});
		add_request(CMD_DATA, 8'h08, 1, 1, {8'h08, 32'h0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SETTINGS) begin
				settle();
				apply_settings(directed_rows[i].dev_type, directed_rows[i].height,
					directed_rows[i].split_by_32);
			end else begin
				offer_request(directed_rows[i].req, directed_rows[i].typed,
					directed_rows[i].n_typed, directed_rows[i].typed_bytes);
			end
		end
		settle();

		// random phases across settings, extremes of cell height included
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: apply_settings(1'b0, 4'd8, 1'b0);
				1: apply_settings(1'b0, 4'd1, 1'b1);
				2: apply_settings(1'b1, 4'd8, 1'b1);
				3: apply_settings(1'b1, 4'd1, 1'b0);
				4: apply_settings(1'b0, 4'd0, 1'b1);
				5: apply_settings(1'b0, 4'd15, 1'b0);
				default: apply_settings(1'b1, 4'd11, 1'b1);
			endcase
			// long receiver hold-off while requests keep coming
			if (p == 1)
				hold_pending = 1'b1;
			// no idling on either side for a whole phase
			if (p == 2)
				steady = 1'b1;
			if (p == 3) begin
				// sender pauses mid-phase until every byte has come out
				random_phase(PHASE_REQUESTS / 2);
				settle();
				random_phase(PHASE_REQUESTS - PHASE_REQUESTS / 2);
			end else begin
				random_phase(PHASE_REQUESTS);
			end
			steady = 1'b0;
			settle();
		end

		// second module type with height 0: define mode holds, data bytes are absorbed
		apply_settings(1'b1, 4'd0, 1'b0);
		r.command = CMD_INSTR;
		r.value = {2'b01, 6'($urandom)};
		offer_request(r, 1'b0, 0, '0);
		repeat (ABSORB_ROWS) begin
			r.command = CMD_DATA;
			r.value = 8'($urandom);
			offer_request(r, 1'b0, 0, '0);
		end
		r.command = CMD_INSTR;
		r.value = {1'b1, 7'($urandom)};
		offer_request(r, 1'b0, 0, '0);
		settle();

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
